>>> rtl/run_tile_opaque_bounding_box_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the opaque bounding box block
// Same-cycle and next-cycle implication checks, reset masked.
// ---------------------------------------------------------------------------
`ifndef RUN_TILE_OPAQUE_BOUNDING_BOX_MACROS_SVH
`define RUN_TILE_OPAQUE_BOUNDING_BOX_MACROS_SVH

// Check that cond implies prop in the same cycle
`define RTOBB_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that cond implies prop in the next cycle
`define RTOBB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/rtobb_pkg.sv
// ---------------------------------------------------------------------------
// rtobb_pkg
// Shared limits, result codes and the command format passed front to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtobb_pkg;

  localparam int WIDTH_LIMIT       = 1024;
  localparam int HEIGHT_BYTE_LIMIT = 5120;
  localparam int HEIGHT_LIMIT      = HEIGHT_BYTE_LIMIT / 2;
  localparam int SEGMENT_LIMIT     = 2048;
  localparam int FLAG_WORDS        = 2;
  localparam int COL_MAX           = 4095;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = 2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_WIDTH  = 2'd1,
    ST_BAD_HEIGHT = 2'd2,
    ST_OVERRUN    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_BOX_INIT = 2'd0,
    OP_PIXEL    = 2'd1,
    OP_EMIT_OK  = 2'd2,
    OP_EMIT_ERR = 2'd3
  } op_t;

  // col/row carry the pixel position, or width/height for a box init
  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [11:0] col;
    logic [11:0] row;
  } cmd_t;

endpackage

>>> rtl/rtobb_queue.sv
// ---------------------------------------------------------------------------
// rtobb_queue
// Short command queue between the parser and the box tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtobb_queue import rtobb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/rtobb_front.sv
// ---------------------------------------------------------------------------
// rtobb_front
// Record parser: walks the header and segments, issues box commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtobb_front import rtobb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] word,
  input  logic        record_start,
  output logic        push,
  output cmd_t        push_cmd
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_FLAGS, PH_WIDTH, PH_HEIGHT, PH_OFFSETS, PH_SKIP, PH_RUN, PH_PIXELS
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  flag_words_left, flag_words_left_next;
  logic [9:0]  sprite_width, sprite_width_next;
  logic [11:0] sprite_height, sprite_height_next;
  logic [11:0] offset_words_left, offset_words_left_next;
  logic [11:0] row, row_next;
  logic [11:0] column, column_next;
  logic [15:0] pending_skip, pending_skip_next;
  logic [10:0] pixels_left, pixels_left_next;

  logic [16:0] seg_sum;
  logic [12:0] col_skip;
  logic [12:0] row_inc;
  logic [1:0]  flag_dec;
  logic [11:0] offset_dec;
  logic [10:0] pixels_dec;

  assign seg_sum    = {1'b0, pending_skip} + {1'b0, word};
  assign col_skip   = {1'b0, column} + {2'b0, pending_skip[10:0]};
  assign row_inc    = {1'b0, row} + 13'd1;
  assign flag_dec   = (flag_words_left != '0) ? flag_words_left - 1'b1 : '0;
  assign offset_dec = (offset_words_left != '0) ? offset_words_left - 1'b1 : '0;
  assign pixels_dec = (pixels_left != '0) ? pixels_left - 1'b1 : '0;

  always_comb begin
    phase_next             = phase;
    flag_words_left_next   = flag_words_left;
    sprite_width_next      = sprite_width;
    sprite_height_next     = sprite_height;
    offset_words_left_next = offset_words_left;
    row_next               = row;
    column_next            = column;
    pending_skip_next      = pending_skip;
    pixels_left_next       = pixels_left;
    push                   = 1'b0;
    push_cmd               = '{op: OP_PIXEL, status: ST_OK, col: column, row: row};

    if (accept) begin
      if (record_start) begin
        phase_next           = PH_FLAGS;
        flag_words_left_next = 2'(FLAG_WORDS - 1);
      end else begin
        unique case (phase)
          PH_IDLE: begin
          end
          PH_FLAGS: begin
            flag_words_left_next = flag_dec;
            if (flag_dec == '0) begin
              phase_next = PH_WIDTH;
            end
          end
          PH_WIDTH: begin
            if (word == '0 || word >= 16'(WIDTH_LIMIT)) begin
              push            = 1'b1;
              push_cmd.op     = OP_EMIT_ERR;
              push_cmd.status = ST_BAD_WIDTH;
              phase_next      = PH_IDLE;
            end else begin
              sprite_width_next = word[9:0];
              phase_next        = PH_HEIGHT;
            end
          end
          PH_HEIGHT: begin
            if (word == '0 || {1'b0, word} > 17'(HEIGHT_LIMIT)) begin
              push            = 1'b1;
              push_cmd.op     = OP_EMIT_ERR;
              push_cmd.status = ST_BAD_HEIGHT;
              phase_next      = PH_IDLE;
            end else begin
              sprite_height_next     = word[11:0];
              offset_words_left_next = word[11:0];
              row_next               = '0;
              column_next            = '0;
              push                   = 1'b1;
              push_cmd.op            = OP_BOX_INIT;
              push_cmd.col           = {2'b0, sprite_width};
              push_cmd.row           = word[11:0];
              phase_next             = PH_OFFSETS;
            end
          end
          PH_OFFSETS: begin
            offset_words_left_next = offset_dec;
            if (offset_dec == '0) begin
              phase_next = PH_SKIP;
            end
          end
          PH_SKIP: begin
            pending_skip_next = word;
            phase_next        = PH_RUN;
          end
          PH_RUN: begin
            if (seg_sum >= 17'(SEGMENT_LIMIT)) begin
              push            = 1'b1;
              push_cmd.op     = OP_EMIT_ERR;
              push_cmd.status = ST_OVERRUN;
              phase_next      = PH_IDLE;
            end else if (seg_sum == '0) begin
              // end of line: advance the row, finish after the last one
              column_next = '0;
              row_next    = row_inc[11:0];
              if (row_inc >= {1'b0, sprite_height}) begin
                push        = 1'b1;
                push_cmd.op = OP_EMIT_OK;
                phase_next  = PH_IDLE;
              end else begin
                phase_next = PH_SKIP;
              end
            end else begin
              column_next      = (col_skip > 13'(COL_MAX)) ? 12'(COL_MAX) : col_skip[11:0];
              pixels_left_next = word[10:0];
              phase_next       = (word == '0) ? PH_SKIP : PH_PIXELS;
            end
          end
          PH_PIXELS: begin
            push = (word != '0);
            if (column < 12'(COL_MAX)) begin
              column_next = column + 1'b1;
            end
            pixels_left_next = pixels_dec;
            if (pixels_dec == '0) begin
              phase_next = PH_SKIP;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      flag_words_left   <= '0;
      sprite_width      <= '0;
      sprite_height     <= '0;
      offset_words_left <= '0;
      row               <= '0;
      column            <= '0;
      pending_skip      <= '0;
      pixels_left       <= '0;
    end else begin
      phase             <= phase_next;
      flag_words_left   <= flag_words_left_next;
      sprite_width      <= sprite_width_next;
      sprite_height     <= sprite_height_next;
      offset_words_left <= offset_words_left_next;
      row               <= row_next;
      column            <= column_next;
      pending_skip      <= pending_skip_next;
      pixels_left       <= pixels_left_next;
    end
  end

endmodule

>>> rtl/rtobb_back.sv
// ---------------------------------------------------------------------------
// rtobb_back
// Box tracker: keeps opaque extents and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtobb_back import rtobb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [9:0]         left,
  output logic [11:0]        top,
  output logic signed [12:0] span_x,
  output logic signed [12:0] span_y
);

  logic [11:0] min_col;
  logic [11:0] max_col;
  logic [11:0] min_row;
  logic [11:0] max_row;
  logic        is_emit;
  logic        out_free;

  assign is_emit  = (cmd.op == OP_EMIT_OK) || (cmd.op == OP_EMIT_ERR);
  assign out_free = !result_valid || !result_stall;
  // hold emit commands while a stalled result still occupies the register
  assign cmd_pop  = !cmd_empty && (!is_emit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      min_col      <= '0;
      max_col      <= '0;
      min_row      <= '0;
      max_row      <= '0;
    end else begin
      // load a new result, or drop the one just taken
      if (cmd_pop && is_emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd_pop) begin
        unique case (cmd.op)
          OP_BOX_INIT: begin
            min_col <= cmd.col;
            min_row <= cmd.row;
            max_col <= '0;
            max_row <= '0;
          end
          OP_PIXEL: begin
            if (cmd.col < min_col) min_col <= cmd.col;
            if (cmd.col > max_col) max_col <= cmd.col;
            if (cmd.row < min_row) min_row <= cmd.row;
            if (cmd.row > max_row) max_row <= cmd.row;
          end
          OP_EMIT_OK: begin
            status       <= ST_OK;
            left         <= min_col[9:0];
            top          <= min_row;
            span_x       <= $signed(13'({1'b0, max_col} - {1'b0, min_col}));
            span_y       <= $signed(13'({1'b0, max_row} - {1'b0, min_row}));
          end
          OP_EMIT_ERR: begin
            status       <= cmd.status;
            left         <= '0;
            top          <= '0;
            span_x       <= '0;
            span_y       <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/run_tile_opaque_bounding_box.sv
// The last word's finish command goes through the command queue to the tracker,
// which loads the result register. Throughput: one word per cycle while the
// four-entry command queue has room; the tracker retires one command a cycle
// but a stalled result holds the queue at the next finish command, and the
// parser stalls once all four entries fill. Reset (rst, synchronous, active
// high) idles the parser, empties the queue and drops any pending result.
// ---------------------------------------------------------------------------
// run_tile_opaque_bounding_box
// Opaque bounding box of a run-encoded sprite record, one word per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "run_tile_opaque_bounding_box_macros.svh"

module run_tile_opaque_bounding_box import rtobb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // item channel: one record word per item
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [15:0]        word,
  input  logic               record_start,
  // result channel: one box or error report per record
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [9:0]         left,
  output logic [11:0]        top,
  output logic signed [12:0] span_x,
  output logic signed [12:0] span_y
);

  logic accept;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_pop_cmd;
  logic q_empty;
  logic err_result;
  logic ok_result;
  logic err_fields_zero;

  // Stall the item side only when the command queue is full
  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;

  // Front: parse the record, emit box init, pixel and finish commands
  rtobb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .word         (word),
    .record_start (record_start),
    .push         (q_push),
    .push_cmd     (q_push_cmd)
  );

  // Queue: decouple the parser from the result stall
  rtobb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  // Back: track extents, present results in a registered output stage
  rtobb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (q_pop_cmd),
    .cmd_empty    (q_empty),
    .cmd_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .left         (left),
    .top          (top),
    .span_x       (span_x),
    .span_y       (span_y)
  );

  assign err_result      = result_valid && (status != ST_OK);
  assign ok_result       = result_valid && (status == ST_OK);
  assign err_fields_zero = (left == '0) && (top == '0) && (span_x == '0) && (span_y == '0);

  // Never retire a command from an empty queue
  `RTOBB_ASSERT_SAME(a_pop_not_empty, clk, rst, q_empty, !q_pop, "pop from empty queue")
  // Error reports carry zeroed fields
  `RTOBB_ASSERT_SAME(a_err_zero, clk, rst, err_result, err_fields_zero, "error not zeroed")
  // A good box never starts past the height limit
  `RTOBB_ASSERT_SAME(a_top_range, clk, rst, ok_result, top <= 12'(HEIGHT_LIMIT), "top too big")

endmodule

>>> sim/run_tile_opaque_bounding_box_tb.sv
// ---------------------------------------------------------------------------
// run_tile_opaque_bounding_box_tb
// Feeds run-encoded sprite records word by word and checks every box or
// error report against a cycle-free model of the parser kept in this bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module run_tile_opaque_bounding_box_tb;
  import rtobb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  // Parser stages of the record, as the bench tracks them
  typedef enum {
    P_IDLE, P_FLAGS, P_WIDTH, P_HEIGHT, P_OFFSETS, P_SKIP, P_RUN, P_PIXELS
  } parse_t;

  typedef struct {
    status_t            status;
    logic [9:0]         left;
    logic [11:0]        top;
    logic signed [12:0] span_x;
    logic signed [12:0] span_y;
  } box_t;

  typedef struct {
    logic [15:0] w;
    bit          s;
  } word_item_t;

  // -------------------------------------------------------------------------
  // Box tracker: follows the record word by word and queues the box (or the
  // error report) that each accepted item should produce.
  // -------------------------------------------------------------------------
  class box_tracker;
    box_t        expected_boxes[$];
    int          failures = 0;
    parse_t      stage = P_IDLE;
    logic [1:0]  flags_left = '0;
    logic [9:0]  spr_w = '0;
    logic [11:0] spr_h = '0;
    logic [11:0] offs_left = '0;
    logic [11:0] cur_row = '0;
    logic [11:0] cur_col = '0;
    logic [15:0] skip_held = '0;
    logic [10:0] px_left = '0;
    logic [11:0] min_col = '0;
    logic [11:0] max_col = '0;
    logic [11:0] min_row = '0;
    logic [11:0] max_row = '0;

    function int pending();
      return expected_boxes.size();
    endfunction

    function void post(status_t st, logic [9:0] l, logic [11:0] t,
                       logic [12:0] sx, logic [12:0] sy);
      expected_boxes.push_back('{st, l, t, sx, sy});
      stage = P_IDLE;
    endfunction

    function void take_word(logic [15:0] w, bit start);
      logic [16:0] seg_sum;
      logic [16:0] col_sum;
      // A start word is itself the first flag word, whatever the stage
      if (start) begin
        stage = P_FLAGS;
        flags_left = 2'(FLAG_WORDS - 1);
        return;
      end
      case (stage)
        P_FLAGS: begin
          if (flags_left != 0) flags_left--;
          if (flags_left == 0) stage = P_WIDTH;
        end
        P_WIDTH: begin
          if (w == 0 || w >= WIDTH_LIMIT) post(ST_BAD_WIDTH, '0, '0, '0, '0);
          else begin
            spr_w = w[9:0];
            stage = P_HEIGHT;
          end
        end
        P_HEIGHT: begin
          if (w == 0 || w > HEIGHT_LIMIT) post(ST_BAD_HEIGHT, '0, '0, '0, '0);
          else begin
            spr_h = w[11:0];
            offs_left = w[11:0];
            cur_row = '0;
            cur_col = '0;
            min_col = {2'b00, spr_w};
            min_row = w[11:0];
            max_col = '0;
            max_row = '0;
            stage = P_OFFSETS;
          end
        end
        P_OFFSETS: begin
          if (offs_left != 0) offs_left--;
          if (offs_left == 0) stage = P_SKIP;
        end
        P_SKIP: begin
          skip_held = w;
          stage = P_RUN;
        end
        P_RUN: begin
          seg_sum = {1'b0, skip_held} + {1'b0, w};
          if (seg_sum >= SEGMENT_LIMIT) post(ST_OVERRUN, '0, '0, '0, '0);
          else if (seg_sum == 0) begin
            // zero pair closes the line; the last line closes the record
            cur_col = '0;
            cur_row++;
            if (cur_row >= spr_h)
              post(ST_OK, min_col[9:0], min_row,
                   13'(max_col) - 13'(min_col), 13'(max_row) - 13'(min_row));
            else stage = P_SKIP;
          end else begin
            col_sum = {5'b0, cur_col} + {1'b0, skip_held};
            cur_col = (col_sum > COL_MAX) ? 12'(COL_MAX) : col_sum[11:0];
            px_left = w[10:0];
            stage = (w == 0) ? P_SKIP : P_PIXELS;
          end
        end
        P_PIXELS: begin
          if (w != 0) begin
            if (cur_col < min_col) min_col = cur_col;
            if (cur_col > max_col) max_col = cur_col;
            if (cur_row < min_row) min_row = cur_row;
            if (cur_row > max_row) max_row = cur_row;
          end
          if (cur_col < COL_MAX) cur_col++;
          if (px_left != 0) px_left--;
          if (px_left == 0) stage = P_SKIP;
        end
        default: ;
      endcase
    endfunction

    function void compare(string what, logic signed [31:0] want,
                          logic signed [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, what, want, got);
        failures++;
      end
    endfunction

    function void check_box(logic [1:0] st, logic [9:0] l, logic [11:0] t,
                            logic signed [12:0] sx, logic signed [12:0] sy);
      box_t want;
      if (expected_boxes.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d",
                 $time, st);
        failures++;
        return;
      end
      want = expected_boxes.pop_front();
      compare("status", want.status, st);
      compare("left", want.left, l);
      compare("top", want.top, t);
      compare("span_x", want.span_x, sx);
      compare("span_y", want.span_y, sy);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Block signals
  // -------------------------------------------------------------------------
  logic               clk;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [15:0]        word = '0;
  logic               record_start = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         status;
  logic [9:0]         left;
  logic [11:0]        top;
  logic signed [12:0] span_x;
  logic signed [12:0] span_y;

  box_tracker boxes = new();
  word_item_t rec[$];

  // Idling switches and the long hold request for the result side
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int hold_ask   = 0;
  int hold_left  = 0;
  int burst_left = 0;
  int cycles     = 0;

  run_tile_opaque_bounding_box dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .word         (word),
    .record_start (record_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .left         (left),
    .top          (top),
    .span_x       (span_x),
    .span_y       (span_y)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side stall: a long hold when asked, otherwise random bursts while
  // idling is switched on. Change only at the falling edge.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_ask != 0) begin
        hold_left = hold_ask;
        hold_ask = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        result_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 10);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Check every result taken at a rising edge against the oldest box
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        boxes.check_box(status, left, top, span_x, span_y);
    end
  end

  // -------------------------------------------------------------------------
  // Driving
  // -------------------------------------------------------------------------

  // Offer one item from the falling edge, optionally after a gap, and hold
  // it until a rising edge takes it.
  task automatic send_word(logic [15:0] w, bit s);
    int gap;
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid   <= 1'b1;
    word         <= w;
    record_start <= s;
    do @(posedge clk); while (item_stall);
    boxes.take_word(w, s);
  endtask

  task automatic flush_record();
    foreach (rec[i]) send_word(rec[i].w, rec[i].s);
    rec.delete();
  endtask

  // Drop the offer, then hold the sender until every queued box has come back
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (boxes.pending() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Record building
  // -------------------------------------------------------------------------
  function automatic void put(logic [15:0] w, bit s = 1'b0);
    rec.push_back('{w, s});
  endfunction

  // Start word, second flag word, width, height and, on request, one
  // line-offset word per line with random content
  function automatic void put_header(logic [15:0] width, logic [15:0] height,
                                     bit with_offsets);
    put(16'($urandom), 1'b1);
    put(16'($urandom));
    put(width);
    put(height);
    if (with_offsets) repeat (height) put(16'($urandom));
  endfunction

  // One segment; skip 0 with run 0 is the end-of-line pair
  function automatic void put_seg(int skip, int run, int opaque_pct);
    put(16'(skip));
    put(16'(run));
    repeat (run)
      put(($urandom_range(0, 99) < opaque_pct) ? 16'($urandom_range(1, 65535))
                                               : 16'h0000);
  endfunction

  function automatic void put_box_record(int max_w, int max_h);
    int width;
    int height;
    int skip;
    int run;
    width  = $urandom_range(1, max_w);
    height = $urandom_range(1, max_h);
    put_header(16'(width), 16'(height), 1'b1);
    for (int ln = 0; ln < height; ln++) begin
      repeat ($urandom_range(0, 3)) begin
        // now and then a long skip, to push the column to saturation
        if ($urandom_range(0, 9) == 0) begin
          skip = $urandom_range(1500, 2040);
          run  = $urandom_range(0, 6);
        end else begin
          skip = $urandom_range(0, width);
          run  = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                             : $urandom_range(0, 6);
        end
        if (skip + run == 0) run = 1;
        put_seg(skip, run, 70);
      end
      put_seg(0, 0, 0);
    end
  endfunction

  // Mostly well-formed records; the rest broken headers, overruns,
  // truncated records cut short by the next start, and stray words.
  function automatic void put_random_record();
    int skip;
    int cut;
    case ($urandom_range(0, 19))
      0: begin
        put_header($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1024, 65535)),
                   16'($urandom_range(1, 4)), 1'b0);
        put(16'($urandom));
      end
      1: put_header(16'($urandom_range(1, 1023)),
                    $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2561, 65535)),
                    1'b0);
      2: begin
        put_header(16'($urandom_range(1, 30)), 16'($urandom_range(1, 3)), 1'b1);
        if ($urandom_range(0, 1)) put_seg($urandom_range(0, 10), $urandom_range(1, 4), 70);
        skip = $urandom_range(0, 65535);
        put(16'(skip));
        put(16'((skip >= SEGMENT_LIMIT) ? $urandom_range(0, 65535)
                                        : $urandom_range(SEGMENT_LIMIT - skip, 65535)));
      end
      3: begin
        put_box_record(40, 4);
        cut = $urandom_range(1, rec.size() - 1);
        rec = rec[0:cut-1];
      end
      4: repeat ($urandom_range(1, 4)) put(16'($urandom));
      default: put_box_record(($urandom_range(0, 7) == 0) ? 1023 : 40,
                              ($urandom_range(0, 7) == 0) ? 8 : 3);
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Directed records: field extremes and every special case
  // -------------------------------------------------------------------------
  task automatic run_directed();
    // smallest legal sprite with no opaque pixel: box comes back empty
    put_header(16'd1, 16'd1, 1'b1);
    put_seg(0, 0, 0);

    // widest legal sprite: two long skips take the column to the top,
    // an empty run only moves the column, then a plain run
    put_header(16'd1023, 16'd2, 1'b1);
    put_seg(0, 1, 100);
    put_seg(2047, 0, 0);
    put_seg(2047, 0, 0);
    put_seg(0, 1, 100);
    put_seg(0, 0, 0);
    put_seg(5, 0, 0);
    put_seg(0, 20, 50);
    put_seg(0, 0, 0);

    // bad widths: zero, the limit, all ones
    put_header(16'd0, 16'd3, 1'b0);
    put_header(16'd1024, 16'd3, 1'b0);
    put_header(16'hFFFF, 16'd3, 1'b0);

    // bad heights: zero, one past the limit, all ones
    put_header(16'd4, 16'd0, 1'b0);
    put_header(16'd4, 16'd2561, 1'b0);
    put_header(16'd4, 16'hFFFF, 1'b0);

    // segment overruns from the skip, the run, both, and right at the limit
    put_header(16'd4, 16'd1, 1'b1); put(16'd2048);  put(16'd0);
    put_header(16'd4, 16'd1, 1'b1); put(16'd0);     put(16'd2048);
    put_header(16'd4, 16'd1, 1'b1); put(16'hFFFF);  put(16'hFFFF);
    put_header(16'd4, 16'd1, 1'b1); put(16'd1000);  put(16'd1048);

    // stray words while idle are dropped
    put(16'hA5A5);
    put(16'h5A5A);

    // restart in the middle of a run of pixels
    put_header(16'd6, 16'd2, 1'b1);
    put(16'd0); put(16'd5); put(16'h1234); put(16'h0000);
    put_header(16'd6, 16'd2, 1'b1);
    put_seg(2, 3, 100);
    put_seg(0, 0, 0);
    put_seg(0, 2, 0);
    put_seg(0, 0, 0);

    // two starts in a row: the second one restarts the flag count
    put(16'h0000, 1'b1);
    put(16'hFFFF, 1'b1);
    put(16'hFFFF);
    put(16'd3);
    put(16'd1);
    put(16'($urandom));
    put_seg(1, 1, 100);
    put_seg(0, 0, 0);

    // a taller sprite, opaque only on its first and last lines
    put_header(16'd7, 16'd8, 1'b1);
    for (int ln = 0; ln < 8; ln++) begin
      if (ln == 0 || ln == 7) put_seg(3, 1, 100);
      put_seg(0, 0, 0);
    end

    flush_record();
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_directed();

    for (int n = 0; n < 6; n++) begin
      // switch idling per record so some records run back to back
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (n == 3) begin
        // pause the sender until everything is back, then hold results off
        // for a long stretch while records keep coming, so the queue fills
        drain();
        hold_ask = 300;
        repeat (4) begin
          put_box_record(4, 2);
          flush_record();
        end
        drain();
      end
      put_random_record();
      flush_record();
    end

    // last part: no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (2) begin
      put_random_record();
      flush_record();
    end

    drain();
    // allow for the block's pipeline to show any stray result
    repeat (8) @(posedge clk);

    if (boxes.failures == 0 && boxes.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
